// ===== hdl/gme_pkg.sv =====
// Package for the grouped-data mode estimator: widths, codes, payload types.
// Used by every module in hdl/; depends on nothing else.

package gme_pkg;

    // Size of a data set and fixed-point format
    localparam int MAX_CLASSES = 256;
    localparam int FRAC_BITS   = 16;

    // Field widths
    localparam int FREQ_W = 16;
    localparam int FLL_W  = 32;
    localparam int CW_W   = 31;
    localparam int MODE_W = 48;
    localparam int CLS_W  = 8;
    localparam int STAT_W = 2;

    // Class index and class counter (counter saturates at MAX_CLASSES + 1)
    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W = $clog2(MAX_CLASSES + 2);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CLASSES);
    localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_CLASSES + 1);

    // Interpolation datapath widths
    localparam int PROD_W = CW_W + FREQ_W;   // class_width * frequency
    localparam int DIFF_W = FREQ_W + 1;      // 2*fmax - fprev - fnext
    localparam int DEN_W  = DIFF_W + 1;      // twice the above
    localparam int NUM_W  = PROD_W + 2;      // 2*width*(fmax-fprev) + divisor/2
    localparam int QUO_W  = CW_W;            // fraction never exceeds class_width
    localparam int SUM_W  = MODE_W + 2;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LOWER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_WIDTH = 1'b1;
    localparam logic [CW_W-1:0] CW_RESET = CW_W'(1) << FRAC_BITS;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVER = 2'd3;

    // Input item
    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              last_class;
    } gme_in_t;

    // Result item
    typedef struct packed {
        logic signed [MODE_W-1:0] mode_value;
        logic [CLS_W-1:0]         modal_class;
        logic [STAT_W-1:0]        status;
    } gme_out_t;

    // Statistics of a closed data set, handed from tracker to sequencer
    typedef struct packed {
        logic [FREQ_W-1:0] best;
        logic [FREQ_W-1:0] prior;
        logic [FREQ_W-1:0] after;
        logic [IDX_W-1:0]  index;
        logic              overflow;
    } gme_snap_t;

endpackage

// ===== hdl/gme_tracker.sv =====
// Streaming statistics: first strict maximum, its neighbours, class count.
// Depends on gme_pkg.

module gme_tracker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  gme_pkg::gme_in_t    item,
    output gme_pkg::gme_snap_t  snap
);

    logic [gme_pkg::FREQ_W-1:0] best_reg, best_next;
    logic [gme_pkg::FREQ_W-1:0] before_reg, before_next;
    logic [gme_pkg::FREQ_W-1:0] after_reg, after_next;
    logic [gme_pkg::FREQ_W-1:0] prev_reg, prev_next;
    logic [gme_pkg::IDX_W-1:0]  index_reg, index_next;
    logic [gme_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       pending_reg, pending_next;
    logic [gme_pkg::IDX_W-1:0]  cur_index;

    assign cur_index = count_reg[gme_pkg::IDX_W-1:0];

    // Update for one item; classes past the limit only push the counter
    always_comb
    begin
        best_next    = best_reg;
        before_next  = before_reg;
        after_next   = after_reg;
        prev_next    = prev_reg;
        index_next   = index_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        if (count_reg < gme_pkg::CNT_LIMIT)
        begin
            if (pending_reg)
            begin
                after_next   = item.frequency;
                pending_next = 1'b0;
            end
            if (item.frequency > best_reg)
            begin
                best_next    = item.frequency;
                index_next   = cur_index;
                before_next  = (count_reg == '0) ? '0 : prev_reg;
                after_next   = '0;
                pending_next = 1'b1;
            end
            prev_next  = item.frequency;
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = gme_pkg::CNT_OVER;
        end
    end

    // Set statistics including the current item
    always_comb
    begin
        snap.best     = best_next;
        snap.prior    = before_next;
        snap.after    = after_next;
        snap.index    = index_next;
        snap.overflow = (count_next == gme_pkg::CNT_OVER);
    end

    // State registers; the last item of a set clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg    <= '0;
            before_reg  <= '0;
            after_reg   <= '0;
            prev_reg    <= '0;
            index_reg   <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (item.last_class)
            begin
                best_reg    <= '0;
                before_reg  <= '0;
                after_reg   <= '0;
                prev_reg    <= '0;
                index_reg   <= '0;
                count_reg   <= '0;
                pending_reg <= 1'b0;
            end
            else
            begin
                best_reg    <= best_next;
                before_reg  <= before_next;
                after_reg   <= after_next;
                prev_reg    <= prev_next;
                index_reg   <= index_next;
                count_reg   <= count_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

// ===== hdl/gme_mul.sv =====
// Bit-serial shift-add multiplier: class_width times a 16-bit operand.
// Depends on gme_pkg. One multiplier bit per cycle, narrow adder only.

module gme_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gme_pkg::CW_W-1:0]    mcand,
    input  logic [gme_pkg::FREQ_W-1:0]  mplier,
    output logic                        done,
    output logic [gme_pkg::PROD_W-1:0]  product
);

    localparam int STEP_W = $clog2(gme_pkg::FREQ_W + 1);

    logic [gme_pkg::CW_W-1:0]   a_reg;
    logic [gme_pkg::CW_W-1:0]   hi_reg, hi_next;
    logic [gme_pkg::FREQ_W-1:0] lo_reg, lo_next;
    logic [STEP_W-1:0]          step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [gme_pkg::CW_W:0]     psum;

    // Add the multiplicand when the low bit is set, then shift right
    always_comb
    begin
        psum    = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next = psum[gme_pkg::CW_W:1];
        lo_next = {psum[0], lo_reg[gme_pkg::FREQ_W-1:1]};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(gme_pkg::FREQ_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= mcand;
            hi_reg <= '0;
            lo_reg <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hdl/gme_div.sv =====
// Bit-serial restoring divider for the interpolated fraction.
// Depends on gme_pkg. One quotient bit per cycle, MSB first.

module gme_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gme_pkg::NUM_W-1:0]   num,
    input  logic [gme_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [gme_pkg::QUO_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(gme_pkg::NUM_W + 1);

    logic [gme_pkg::DEN_W-1:0] den_reg;
    logic [gme_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [gme_pkg::NUM_W-1:0] nq_reg, nq_next;
    logic [STEP_W-1:0]         step_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [gme_pkg::DEN_W:0]   shifted;
    logic                      ge;

    // Shift in the next numerator bit and try a subtract
    always_comb
    begin
        shifted = {rem_reg, nq_reg[gme_pkg::NUM_W-1]};
        ge      = (shifted >= {1'b0, den_reg});
        if (ge)
        begin
            rem_next = gme_pkg::DEN_W'(shifted - {1'b0, den_reg});
        end
        else
        begin
            rem_next = shifted[gme_pkg::DEN_W-1:0];
        end
        nq_next = {nq_reg[gme_pkg::NUM_W-2:0], ge};
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(gme_pkg::NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: remainder and numerator/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            nq_reg  <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign done     = done_reg;
    assign quotient = nq_reg[gme_pkg::QUO_W-1:0];

endmodule

// ===== hdl/grouped_mode_estimator_core.sv =====
// Top level of the grouped-data mode estimator: config, sequencer, output.
// Depends on gme_pkg, gme_tracker, gme_mul, gme_div.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     in_data   (gme_in_t)
//   out      output     out_valid / out_ready   out_data  (gme_out_t)
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Frequencies are taken one item per cycle while the block is idle.
// The item marked last starts the interpolation: a 16-step serial multiply,
// then a 49-step serial divide (overlapped with a second multiply) and a
// final add.
// Sets that are all zero or too long skip the arithmetic.
// The result waits in an output register; new items are taken meanwhile.
// Reset clears the running set statistics and loads the register defaults.

module grouped_mode_estimator_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gme_pkg::gme_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gme_pkg::gme_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gme_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gme_pkg::CFG_W-1:0]       cfg_data
);

    localparam int MODE_TOP = gme_pkg::MODE_W - 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MULV = 5'b00100,
        S_DIV  = 5'b01000,
        S_SUM  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [gme_pkg::FLL_W-1:0]  fll_reg;
    logic [gme_pkg::CW_W-1:0]   cw_reg;
    gme_pkg::gme_snap_t         snap;
    gme_pkg::gme_snap_t         snap_reg;
    gme_pkg::gme_out_t          out_reg, out_next;
    logic                       out_valid_reg;

    logic                       in_accept;
    logic                       special;
    logic                       slot_free;
    logic                       out_load;
    logic [gme_pkg::FREQ_W-1:0] v_diff;
    logic [gme_pkg::DIFF_W-1:0] b_diff;

    logic                       mul_start, mul_done;
    logic [gme_pkg::FREQ_W-1:0] mul_b;
    logic [gme_pkg::PROD_W-1:0] mul_prod;
    logic                       div_start, div_done;
    logic [gme_pkg::NUM_W-1:0]  div_num;
    logic [gme_pkg::DEN_W-1:0]  div_den;
    logic [gme_pkg::QUO_W-1:0]  div_quo;

    logic [gme_pkg::SUM_W-1:0]          sum;
    logic [gme_pkg::SUM_W-MODE_TOP-1:0] sum_top;
    logic                               sum_ok;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fll_reg <= '0;
            cw_reg  <= gme_pkg::CW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gme_pkg::REG_FIRST_LOWER: fll_reg <= cfg_data[gme_pkg::FLL_W-1:0];
                gme_pkg::REG_CLASS_WIDTH: cw_reg  <= cfg_data[gme_pkg::CW_W-1:0];
                default:                  fll_reg <= fll_reg;
            endcase
        end
    end

    // Streaming statistics
    gme_tracker u_tracker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .snap   (snap)
    );

    // Closed set
    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.last_class)
        begin
            snap_reg <= snap;
        end
    end

    // Interpolation operands: numerator and divisor differences
    assign special = snap_reg.overflow || (snap_reg.best == '0);
    assign v_diff  = snap_reg.best - snap_reg.prior;
    assign b_diff  = {snap_reg.best, 1'b0} - gme_pkg::DIFF_W'(snap_reg.prior)
                     - gme_pkg::DIFF_W'(snap_reg.after);

    // First multiply: width * (fmax - fprev); second: index * width
    assign mul_start = ((state_reg == S_LOAD) && !special)
                       || ((state_reg == S_MULV) && mul_done);
    assign mul_b     = (state_reg == S_LOAD) ? v_diff
                       : gme_pkg::FREQ_W'(snap_reg.index);

    gme_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (cw_reg),
        .mplier  (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Rounded fraction: (2*P + b) / (2*b)
    assign div_start = (state_reg == S_MULV) && mul_done;
    assign div_num   = {1'b0, mul_prod, 1'b0} + gme_pkg::NUM_W'(b_diff);
    assign div_den   = {b_diff, 1'b0};

    gme_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Final sum and saturation
    always_comb
    begin
        sum = {{(gme_pkg::SUM_W - gme_pkg::FLL_W){fll_reg[gme_pkg::FLL_W-1]}}, fll_reg}
              + gme_pkg::SUM_W'(mul_prod) + gme_pkg::SUM_W'(div_quo);
        sum_top = sum[gme_pkg::SUM_W-1:MODE_TOP];
        sum_ok  = (&sum_top) || !(|sum_top);

        if (snap_reg.overflow)
        begin
            out_next.mode_value  = '0;
            out_next.modal_class = '0;
            out_next.status      = gme_pkg::ST_OVER;
        end
        else if (snap_reg.best == '0)
        begin
            out_next.mode_value  = '0;
            out_next.modal_class = '0;
            out_next.status      = gme_pkg::ST_ZERO;
        end
        else
        begin
            out_next.modal_class = gme_pkg::CLS_W'(snap_reg.index);
            if (sum_ok)
            begin
                out_next.mode_value = sum[gme_pkg::MODE_W-1:0];
                out_next.status     = gme_pkg::ST_OK;
            end
            else
            begin
                out_next.mode_value = {sum[gme_pkg::SUM_W-1],
                                       {MODE_TOP{~sum[gme_pkg::SUM_W-1]}}};
                out_next.status     = gme_pkg::ST_SAT;
            end
        end
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_SUM) && slot_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && in_data.last_class)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = special ? S_SUM : S_MULV;
            end
            S_MULV:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sim/grouped_mode_estimator_core_tb.sv =====
// Self-checking testbench for grouped_mode_estimator_core: streams histograms,
// predicts the interpolated mode and compares every result item.
// Depends on gme_pkg and the RTL in hdl/.

module grouped_mode_estimator_core_tb;

    import gme_pkg::*;

    localparam longint MODE_MAX = (longint'(1) <<< 47) - 1;
    localparam longint MODE_MIN = -(longint'(1) <<< 47);
    localparam int SETTLE = 150;       // cycles for one interpolation to finish
    localparam int HOLD_CYCLES = 400;  // long receiver stall

    // Predicts each data set's mode and holds the expected result items
    class mode_scoreboard;
        int               base_limit;
        int unsigned      class_step;
        logic [15:0]      top_count;
        logic [7:0]       top_index;
        logic [15:0]      count_before;
        logic [15:0]      count_after;
        logic [15:0]      prev_count;
        int               classes_seen;
        bit               after_due;
        gme_out_t         expected_modes[$];
        int               mismatches;
        int               checked;
        int               items_seen;
        int               n_ok;
        int               n_zero;
        int               n_sat;
        int               n_over;

        function new();
            base_limit = 0;
            class_step = CW_RESET;
            mismatches = 0;
            checked = 0;
            items_seen = 0;
            n_ok = 0;
            n_zero = 0;
            n_sat = 0;
            n_over = 0;
            clear_set();
        endfunction

        function void clear_set();
            top_count = '0;
            top_index = '0;
            count_before = '0;
            count_after = '0;
            prev_count = '0;
            classes_seen = 0;
            after_due = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_FIRST_LOWER)
                base_limit = int'(data);
            else
                class_step = data[30:0];
        endfunction

        // Track one class; on the last class of a set, queue the expected result
        function void note_frequency(gme_in_t item);
            gme_out_t         want;
            longint unsigned  rise;
            longint unsigned  span;
            longint unsigned  frac;
            longint           total;
            items_seen++;
            if (classes_seen < MAX_CLASSES) begin
                if (after_due) begin
                    count_after = item.frequency;
                    after_due = 1'b0;
                end
                if (item.frequency > top_count) begin
                    top_count = item.frequency;
                    top_index = classes_seen[7:0];
                    count_before = (classes_seen == 0) ? 16'd0 : prev_count;
                    count_after = '0;
                    after_due = 1'b1;
                end
                prev_count = item.frequency;
                classes_seen++;
            end
            else begin
                classes_seen = MAX_CLASSES + 1;
            end
            if (!item.last_class)
                return;

            want = '0;
            if (classes_seen > MAX_CLASSES) begin
                want.status = ST_OVER;
                n_over++;
            end
            else if (top_count == 0) begin
                want.status = ST_ZERO;
                n_zero++;
            end
            else begin
                rise = 64'(top_count) - 64'(count_before);
                span = 2 * 64'(top_count) - 64'(count_before) - 64'(count_after);
                frac = 0;
                // fraction rounded to nearest, halves up
                if (span != 0)
                    frac = (64'(class_step) * rise * 2 + span) / (2 * span);
                total = longint'(base_limit) + longint'(64'(top_index) * 64'(class_step))
                      + longint'(frac);
                want.status = ST_OK;
                if (total > MODE_MAX) begin
                    total = MODE_MAX;
                    want.status = ST_SAT;
                end
                else if (total < MODE_MIN) begin
                    total = MODE_MIN;
                    want.status = ST_SAT;
                end
                if (want.status == ST_SAT)
                    n_sat++;
                else
                    n_ok++;
                want.mode_value = total[47:0];
                want.modal_class = top_index;
            end
            expected_modes.push_back(want);
            clear_set();
        endfunction

        // Compare a result item with the oldest expectation
        function void check_mode(gme_out_t got);
            gme_out_t want;
            if (expected_modes.size() == 0) begin
                $display("%0t: unexpected result: mode_value %0d modal_class %0d status %0d",
                         $time, got.mode_value, got.modal_class, got.status);
                mismatches++;
                return;
            end
            want = expected_modes.pop_front();
            checked++;
            if (got.mode_value !== want.mode_value) begin
                $display("%0t: mode_value expected %0d, got %0d",
                         $time, want.mode_value, got.mode_value);
                mismatches++;
            end
            if (got.modal_class !== want.modal_class) begin
                $display("%0t: modal_class expected %0d, got %0d",
                         $time, want.modal_class, got.modal_class);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
        endfunction

        function void close_out();
            if (expected_modes.size() != 0) begin
                $display("%0t: %0d expected results never arrived",
                         $time, expected_modes.size());
                mismatches += expected_modes.size();
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    gme_in_t                in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    gme_out_t               out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    mode_scoreboard sb = new();

    bit no_idle = 1'b0;
    int holds_asked = 0;
    int holds_given = 0;
    int hold_left = 0;

    grouped_mode_estimator_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch both channels for accepted items
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_frequency(in_data);
            if (out_valid && out_ready)
                sb.check_mode(out_data);
        end
    end

    // Receiver: random stalls, long hold-off on request
    always @(posedge clk)
    begin
        if (holds_asked != holds_given)
        begin
            holds_given = holds_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= no_idle || ($urandom_range(99) >= 17);
        end
    end

    function automatic logic [15:0] pick_count();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(0, 15));   // small values make ties
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one class item; returns at the edge where it is taken
    task automatic send_class(input logic [15:0] freq, input logic last);
        gme_in_t item;
        item.frequency = freq;
        item.last_class = last;
        if (!no_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_histogram(input int classes);
        for (int i = 0; i < classes; i++)
            send_class(pick_count(), i == classes - 1);
    endtask

    // Long set with its maximum on the final class
    task automatic send_long(input int classes);
        for (int i = 0; i < classes; i++)
            send_class((i == classes - 1) ? 16'hFFFF : 16'($urandom_range(0, 65534)),
                       i == classes - 1);
    endtask

    // Returns at the accepting edge with cfg_valid still high; the caller drops it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    // Stop offering items, wait for outstanding results, then let the block settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_modes.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_setting(input logic [31:0] lower, input logic [30:0] step,
                               input int sets, input bit quiet, input bit squeeze);
        logic [31:0] word;
        word = $urandom();
        word[30:0] = step;   // top bit of the word is random, unused by the register
        write_register(REG_FIRST_LOWER, lower);
        write_register(REG_CLASS_WIDTH, word);
        cfg_valid <= 1'b0;
        no_idle = quiet;
        if (squeeze)
            holds_asked++;
        repeat (sets) send_histogram($urandom_range(1, 10));
        wait_idle();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets at reset defaults
        send_class(16'd5, 1'b1);                // lone class, no neighbors
        send_class(16'd0, 1'b0);                // all zero
        send_class(16'd0, 1'b0);
        send_class(16'd0, 1'b1);
        send_class(16'd0, 1'b1);                // single zero class
        send_class(16'hFFFF, 1'b0);             // maximum on first class
        send_class(16'd1, 1'b0);
        send_class(16'd2, 1'b1);
        send_class(16'd1, 1'b0);                // maximum on last class
        send_class(16'd2, 1'b0);
        send_class(16'hFFFF, 1'b1);
        send_class(16'd3, 1'b0);                // tie: first maximum wins
        send_class(16'd7, 1'b0);
        send_class(16'd7, 1'b0);
        send_class(16'd2, 1'b1);
        send_class(16'd0, 1'b0);
        send_class(16'hFFFF, 1'b0);
        send_class(16'd0, 1'b1);
        send_class(16'hFFFF, 1'b0);
        send_class(16'hFFFF, 1'b1);
        wait_idle();

        // Most negative lower limit, widest classes
        run_setting(32'h8000_0000, 31'h7FFF_FFFF, 15, 1'b0, 1'b0);

        // Largest lower limit, narrowest classes, then rounding of halves
        run_setting(32'h7FFF_FFFF, 31'd1, 15, 1'b0, 1'b0);
        send_class(16'd1, 1'b0);                // fraction one half: rounds up
        send_class(16'd3, 1'b0);
        send_class(16'd1, 1'b1);
        send_class(16'd2, 1'b0);                // fraction one quarter: rounds down
        send_class(16'd3, 1'b0);
        send_class(16'd0, 1'b1);
        wait_idle();

        // Zero class width: mode is the lower limit
        run_setting($urandom(), 31'd0, 10, 1'b0, 1'b0);

        // Odd width, receiver held off so the block backs up
        run_setting(32'h0, 31'd65537, 25, 1'b0, 1'b1);

        // Full-length set, then sets past the class limit
        run_setting($urandom(), 31'($urandom_range(1, 32'h7FFF_FFFF)), 3, 1'b0, 1'b0);
        send_long(MAX_CLASSES);
        send_long(MAX_CLASSES + 1);
        send_long(MAX_CLASSES + 2);
        wait_idle();

        // No idling on either side
        run_setting($urandom(), 31'($urandom_range(1, 32'h7FFF_FFFF)), 20, 1'b1, 1'b0);
        run_setting($urandom(), 31'($urandom_range(1, 1 << 20)), 10, 1'b0, 1'b0);
        run_setting(32'hFFFF_0000, CW_RESET, 10, 1'b0, 1'b0);

        sb.close_out();
        $display("Run covered %0d class items and %0d results: %0d interpolated, %0d saturated,",
                 sb.items_seen, sb.checked, sb.n_ok, sb.n_sat);
        $display("%0d all-zero sets and %0d over-length sets.", sb.n_zero, sb.n_over);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
